>>> sv/pdr_pkg.sv
// Shared types, codes and constants of the planar dead-reckoning unit.
package pdr_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_IDX_W       = 5;

  localparam logic OP_VEL = 1'b0;
  localparam logic OP_SET = 1'b1;

  localparam logic MODE_RECT = 1'b0;
  localparam logic MODE_TRAP = 1'b1;

  // round(2^32 / pi)
  localparam logic [31:0]        INV_PI_Q32      = 32'd1367130551;
  // round(0.607252935 * 2^30)
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  // 2^39 - 1 ticks
  localparam logic signed [48:0] DT_LIMIT        = 49'sd549755813887;

  typedef struct packed {
    logic               op;
    logic [47:0]        stamp;
    logic signed [23:0] linear_speed;
    logic signed [23:0] yaw_rate;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [15:0] new_heading;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic [47:0]        out_stamp;
    logic signed [23:0] out_speed;
    logic signed [23:0] out_yaw_rate;
  } out_item_t;

  // atan(2^-i) in units of 2^32 = 2*pi
  function automatic logic [31:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] val;
    unique case (idx)
      5'd0:    val = 32'h2000_0000;
      5'd1:    val = 32'h12E4_051E;
      5'd2:    val = 32'h09FB_385B;
      5'd3:    val = 32'h0511_11D4;
      5'd4:    val = 32'h028B_0D43;
      5'd5:    val = 32'h0145_D7E1;
      5'd6:    val = 32'h00A2_F61E;
      5'd7:    val = 32'h0051_7C55;
      5'd8:    val = 32'h0028_BE53;
      5'd9:    val = 32'h0014_5F2F;
      5'd10:   val = 32'h000A_2F98;
      5'd11:   val = 32'h0005_17CC;
      5'd12:   val = 32'h0002_8BE6;
      5'd13:   val = 32'h0001_45F3;
      5'd14:   val = 32'h0000_A2FA;
      5'd15:   val = 32'h0000_517D;
      5'd16:   val = 32'h0000_28BE;
      5'd17:   val = 32'h0000_145F;
      5'd18:   val = 32'h0000_0A30;
      5'd19:   val = 32'h0000_0518;
      5'd20:   val = 32'h0000_028C;
      5'd21:   val = 32'h0000_0146;
      5'd22:   val = 32'h0000_00A3;
      5'd23:   val = 32'h0000_0051;
      default: val = 32'h0000_0000;
    endcase
    return val;
  endfunction

endpackage

>>> sv/planar_dead_reckoning_unit.sv
// Planar dead-reckoning unit: sequenced multiplier and CORDIC pose integrator.
// A velocity beat's result is formed with one shared 32x32 multiplier, used ten times,
// and the CORDIC. The unit takes no new beat until a velocity beat is through and its
// result is in the output register; a set-pose beat gives no result and leaves the unit
// idle. The finished result waits in an output register.
// Reset (rst_n low, synchronous) clears pose, history, mode and the output valid.
module planar_dead_reckoning_unit #(
  parameter int CORDIC_STEPS = pdr_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pdr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pdr_pkg::out_item_t out_data,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data
);
  import pdr_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_PREP    = 12'b0000_0000_0010,
    S_MUL_LO  = 12'b0000_0000_0100,
    S_MUL_HI  = 12'b0000_0000_1000,
    S_MUL_ACC = 12'b0000_0001_0000,
    S_POST    = 12'b0000_0010_0000,
    S_C_INIT  = 12'b0000_0100_0000,
    S_C_ITER  = 12'b0000_1000_0000,
    S_C_FIN   = 12'b0001_0000_0000,
    S_C_ABS   = 12'b0010_0000_0000,
    S_SAT     = 12'b0100_0000_0000,
    S_FIN     = 12'b1000_0000_0000
  } state_t;

  typedef enum logic [2:0] {
    PRD_RATE  = 3'd0,
    PRD_INVPI = 3'd1,
    PRD_SPEED = 3'd2,
    PRD_X     = 3'd3,
    PRD_Y     = 3'd4
  } prod_t;

  localparam logic [ATAN_IDX_W-1:0] LAST_STEP = ATAN_IDX_W'(CORDIC_STEPS - 1);

  state_t state_r, state_nxt;
  prod_t  prod_r;
  logic   mode_r;

  logic signed [31:0] x_acc_r, y_acc_r;
  logic [15:0]        hdg_r;
  logic [47:0]        last_stamp_r;
  logic signed [23:0] last_speed_r, last_rate_r;
  logic               seen_r;

  logic signed [48:0] diff_r;
  logic signed [24:0] rsum_r, ssum_r;
  logic [38:0]        dt_mag_r;
  logic               dt_neg_r;
  logic [24:0]        rt_mag_r, sp_mag_r;
  logic               rt_neg_r, sp_neg_r;

  logic [63:0]        mul_r, acc_r;
  logic [43:0]        d_mag_r;
  logic               d_neg_r;

  logic signed [33:0] cx_r, cy_r;
  logic signed [31:0] cz_r;
  logic               flip_r;
  logic [ATAN_IDX_W-1:0] step_r;
  logic signed [19:0] cos_r, sin_r;
  logic [19:0]        cos_mag_r, sin_mag_r;
  logic               cos_neg_r, sin_neg_r;
  logic signed [48:0] q_r;

  logic      out_valid_r;
  out_item_t out_data_r;

  logic               in_fire, vel_fire, set_fire, trap, out_free;
  logic signed [23:0] prev_rate, prev_speed;
  logic signed [24:0] rsum_nxt, ssum_nxt;
  logic signed [48:0] diff_nxt, diff_abs;
  logic [31:0]        mul_a, mul_b, mul_b_lo, mul_b_hi;
  logic [63:0]        mul_p;
  logic [15:0]        bam, hdg_step;
  logic [63:0]        sp_rnd, sp_sum;
  logic [43:0]        d_mag_nxt;
  logic               q_neg;
  logic signed [64:0] q_full;
  logic signed [33:0] c_dx, c_dy, cx_rnd, cy_rnd;
  logic [31:0]        c_atan, z0;
  logic               z_flip;
  logic signed [31:0] sat_base, sat_res;
  logic signed [49:0] sat_sum;

  assign in_fire  = in_valid && in_ready;
  assign vel_fire = in_fire && (in_data.op == OP_VEL);
  assign set_fire = in_fire && (in_data.op == OP_SET);
  assign trap     = (mode_r == MODE_TRAP);
  assign out_free = !out_valid_r || out_ready;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // first sample: previous velocities equal the current ones, dt is zero
  assign prev_rate  = seen_r ? last_rate_r  : in_data.yaw_rate;
  assign prev_speed = seen_r ? last_speed_r : in_data.linear_speed;
  assign rsum_nxt = trap ? ({in_data.yaw_rate[23], in_data.yaw_rate} + {prev_rate[23], prev_rate})
                         : {in_data.yaw_rate[23], in_data.yaw_rate};
  assign ssum_nxt = trap ? ({in_data.linear_speed[23], in_data.linear_speed}
                            + {prev_speed[23], prev_speed})
                         : {in_data.linear_speed[23], in_data.linear_speed};
  assign diff_nxt = seen_r ? ({1'b0, in_data.stamp} - {1'b0, last_stamp_r}) : 49'sd0;
  assign diff_abs = diff_r[48] ? (49'sd0 - diff_r) : diff_r;

  // shared multiplier operand selection
  always_comb begin
    mul_a    = '0;
    mul_b_lo = '0;
    mul_b_hi = '0;
    unique case (prod_r)
      PRD_RATE: begin
        mul_a    = 32'(rt_mag_r);
        mul_b_lo = dt_mag_r[31:0];
        mul_b_hi = 32'(dt_mag_r[38:32]);
      end
      PRD_INVPI: begin
        mul_a    = INV_PI_Q32;
        mul_b_lo = acc_r[31:0];
        mul_b_hi = acc_r[63:32];
      end
      PRD_SPEED: begin
        mul_a    = 32'(sp_mag_r);
        mul_b_lo = dt_mag_r[31:0];
        mul_b_hi = 32'(dt_mag_r[38:32]);
      end
      PRD_X: begin
        mul_a    = 32'(cos_mag_r);
        mul_b_lo = d_mag_r[31:0];
        mul_b_hi = 32'(d_mag_r[43:32]);
      end
      PRD_Y: begin
        mul_a    = 32'(sin_mag_r);
        mul_b_lo = d_mag_r[31:0];
        mul_b_hi = 32'(d_mag_r[43:32]);
      end
      default: ;
    endcase
  end

  assign mul_b = (state_r == S_MUL_HI) ? mul_b_hi : mul_b_lo;
  assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

  // heading step in binary angle
  assign bam      = trap ? acc_r[37:22] : acc_r[36:21];
  assign hdg_step = (rt_neg_r ^ dt_neg_r) ? (~bam + 16'd1) : bam;

  // step length, floor shift done on the magnitude
  assign sp_rnd    = (sp_neg_r ^ dt_neg_r) ? (trap ? 64'h1F_FFFF : 64'h0F_FFFF) : 64'd0;
  assign sp_sum    = acc_r + sp_rnd;
  assign d_mag_nxt = trap ? {1'b0, sp_sum[63:21]} : sp_sum[63:20];

  assign q_neg  = d_neg_r ^ ((prod_r == PRD_X) ? cos_neg_r : sin_neg_r);
  assign q_full = q_neg ? (65'sd0 - $signed({1'b0, acc_r})) : $signed({1'b0, acc_r});

  // CORDIC step
  assign c_dx   = cy_r >>> step_r;
  assign c_dy   = cx_r >>> step_r;
  assign c_atan = atan_entry(step_r);
  assign z0     = {hdg_r, 16'b0};
  assign z_flip = z0[31] ^ z0[30];
  assign cx_rnd = cx_r + 34'sd8192;
  assign cy_rnd = cy_r + 34'sd8192;

  // saturating position update
  assign sat_base = (prod_r == PRD_X) ? x_acc_r : y_acc_r;
  assign sat_sum  = {{18{sat_base[31]}}, sat_base} + {q_r[48], q_r};
  always_comb begin
    priority if (sat_sum[49:31] == '0 || sat_sum[49:31] == '1) begin
      sat_res = sat_sum[31:0];
    end else if (sat_sum[49]) begin
      sat_res = 32'sh8000_0000;
    end else begin
      sat_res = 32'sh7FFF_FFFF;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (vel_fire) state_nxt = S_PREP;
      S_PREP:    state_nxt = S_MUL_LO;
      S_MUL_LO:  state_nxt = S_MUL_HI;
      S_MUL_HI:  state_nxt = S_MUL_ACC;
      S_MUL_ACC: state_nxt = (prod_r == PRD_RATE) ? S_MUL_LO : S_POST;
      S_POST: begin
        priority if (prod_r == PRD_INVPI) begin
          state_nxt = S_MUL_LO;
        end else if (prod_r == PRD_SPEED) begin
          state_nxt = S_C_INIT;
        end else begin
          state_nxt = S_SAT;
        end
      end
      S_C_INIT:  state_nxt = S_C_ITER;
      S_C_ITER:  if (step_r == LAST_STEP) state_nxt = S_C_FIN;
      S_C_FIN:   state_nxt = S_C_ABS;
      S_C_ABS:   state_nxt = S_MUL_LO;
      S_SAT:     state_nxt = (prod_r == PRD_X) ? S_MUL_LO : S_FIN;
      S_FIN:     if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // control and pose state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      prod_r       <= PRD_RATE;
      mode_r       <= MODE_RECT;
      x_acc_r      <= '0;
      y_acc_r      <= '0;
      hdg_r        <= '0;
      last_stamp_r <= '0;
      last_speed_r <= '0;
      last_rate_r  <= '0;
      seen_r       <= 1'b0;
      step_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (set_fire) begin
        x_acc_r <= in_data.new_x;
        y_acc_r <= in_data.new_y;
        hdg_r   <= in_data.new_heading;
      end
      if (vel_fire) begin
        last_stamp_r <= in_data.stamp;
        last_speed_r <= in_data.linear_speed;
        last_rate_r  <= in_data.yaw_rate;
        seen_r       <= 1'b1;
      end
      if (state_r == S_PREP) begin
        prod_r <= PRD_RATE;
      end
      if (state_r == S_MUL_ACC && prod_r == PRD_RATE) begin
        prod_r <= PRD_INVPI;
      end
      if (state_r == S_POST && prod_r == PRD_INVPI) begin
        hdg_r  <= hdg_r + hdg_step;
        prod_r <= PRD_SPEED;
      end
      if (state_r == S_C_INIT) begin
        step_r <= '0;
      end
      if (state_r == S_C_ITER) begin
        step_r <= step_r + 1'b1;
      end
      if (state_r == S_C_ABS) begin
        prod_r <= PRD_X;
      end
      if (state_r == S_SAT) begin
        if (prod_r == PRD_X) begin
          x_acc_r <= sat_res;
          prod_r  <= PRD_Y;
        end else begin
          y_acc_r <= sat_res;
        end
      end
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (vel_fire) begin
      diff_r <= diff_nxt;
      rsum_r <= rsum_nxt;
      ssum_r <= ssum_nxt;
    end
    if (state_r == S_PREP) begin
      priority if (diff_r > DT_LIMIT) begin
        dt_mag_r <= DT_LIMIT[38:0];
        dt_neg_r <= 1'b0;
      end else if (diff_r < -DT_LIMIT) begin
        dt_mag_r <= DT_LIMIT[38:0];
        dt_neg_r <= 1'b1;
      end else begin
        dt_mag_r <= diff_abs[38:0];
        dt_neg_r <= diff_r[48];
      end
      rt_mag_r <= rsum_r[24] ? (25'd0 - rsum_r) : rsum_r;
      rt_neg_r <= rsum_r[24];
      sp_mag_r <= ssum_r[24] ? (25'd0 - ssum_r) : ssum_r;
      sp_neg_r <= ssum_r[24];
    end
    if (state_r == S_MUL_LO || state_r == S_MUL_HI) begin
      mul_r <= mul_p;
    end
    if (state_r == S_MUL_HI) begin
      acc_r <= (prod_r == PRD_INVPI) ? {32'b0, mul_r[63:32]} : mul_r;
    end
    if (state_r == S_MUL_ACC) begin
      acc_r <= acc_r + ((prod_r == PRD_INVPI) ? mul_r : {mul_r[31:0], 32'b0});
    end
    if (state_r == S_POST) begin
      if (prod_r == PRD_SPEED) begin
        d_mag_r <= d_mag_nxt;
        d_neg_r <= sp_neg_r ^ dt_neg_r;
      end
      q_r <= q_full[64:16];
    end
    if (state_r == S_C_INIT) begin
      cx_r   <= CORDIC_GAIN_Q30;
      cy_r   <= '0;
      cz_r   <= z_flip ? {~z0[31], z0[30:0]} : z0;
      flip_r <= z_flip;
    end
    if (state_r == S_C_ITER) begin
      if (!cz_r[31]) begin
        cx_r <= cx_r - c_dx;
        cy_r <= cy_r + c_dy;
        cz_r <= cz_r - c_atan;
      end else begin
        cx_r <= cx_r + c_dx;
        cy_r <= cy_r - c_dy;
        cz_r <= cz_r + c_atan;
      end
    end
    if (state_r == S_C_FIN) begin
      cos_r <= cx_rnd[33:14];
      sin_r <= cy_rnd[33:14];
    end
    if (state_r == S_C_ABS) begin
      cos_mag_r <= cos_r[19] ? (20'd0 - cos_r) : cos_r;
      cos_neg_r <= cos_r[19] ^ flip_r;
      sin_mag_r <= sin_r[19] ? (20'd0 - sin_r) : sin_r;
      sin_neg_r <= sin_r[19] ^ flip_r;
    end
    if (state_r == S_FIN && out_free) begin
      out_data_r.pos_x        <= x_acc_r;
      out_data_r.pos_y        <= y_acc_r;
      out_data_r.heading      <= hdg_r;
      out_data_r.out_stamp    <= last_stamp_r;
      out_data_r.out_speed    <= last_speed_r;
      out_data_r.out_yaw_rate <= last_rate_r;
    end
  end

endmodule

>>> sv/pdr_checker.sv
// Port-level checks of the planar dead-reckoning unit and their bind.
module pdr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input pdr_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input pdr_pkg::out_item_t out_data
);
  import pdr_pkg::*;

  // a velocity beat keeps the unit busy
  a_busy_after_vel: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.op == OP_VEL |=> !in_ready)
    else $error("input taken again right after a velocity beat");

  // set pose gives no result
  a_set_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.op == OP_SET && !out_valid |=> !out_valid)
    else $error("result raised by a set-pose beat");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat dropped or changed");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("unit not idle after reset");

endmodule

bind planar_dead_reckoning_unit pdr_checker u_pdr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
